@@ rtl/rgbnd_pkg.sv @@
// Shared types, constants and a helper function of the RGB565 nearest-neighbor downscaler.
`timescale 1ns / 1ps
`default_nettype none
package rgbnd_pkg;

  localparam int TargetWidth  = 224;
  localparam int TargetHeight = 224;
  localparam int MaxSourceDim = 4095;

  localparam int SizeW  = 12;
  localparam int PixelW = 16;
  localparam int ChanW  = 8;
  localparam int CoordW = 8;
  localparam int TgtColW = $clog2(TargetWidth + 1);
  localparam int TgtRowW = $clog2(TargetHeight + 1);

  localparam int ColDen = 2 * TargetWidth;
  localparam int RowDen = 2 * TargetHeight;
  localparam int MaxDen = (ColDen > RowDen) ? ColDen : RowDen;
  localparam int MinDen = (ColDen < RowDen) ? ColDen : RowDen;
  localparam int DenW   = $clog2(MaxDen + 1);
  localparam int RemW   = $clog2(MaxDen);
  localparam int QW     = $clog2(MaxSourceDim / MinDen + 1);

  localparam int RstWidth  = 320;
  localparam int RstHeight = 240;

  localparam int FifoDepth = 4;

  typedef enum logic [0:0] {
    RegSourceWidth  = 1'b0,
    RegSourceHeight = 1'b1
  } reg_idx_e;

  // Quotient and remainder of a size over the pick denominator, and of twice the size.
  typedef struct packed {
    logic [QW-1:0]   base_q;
    logic [RemW-1:0] base_r;
    logic [QW:0]     step_q;
    logic [RemW-1:0] step_r;
  } split_t;

  typedef struct packed {
    logic              last;
    logic [CoordW-1:0] ty;
    logic [CoordW-1:0] tx;
    logic [PixelW-1:0] pixel;
  } pick_item_t;

  function automatic split_t size_split(logic [SizeW-1:0] size, logic [DenW-1:0] den);
    split_t s;
    logic [SizeW-1:0] rem;
    logic [SizeW+QW-1:0] trial;
    logic [RemW:0] dbl;
    rem = size;
    s.base_q = '0;
    for (int b = QW - 1; b >= 0; b--) begin
      trial = (SizeW+QW)'(den) << b;
      if ({{QW{1'b0}}, rem} >= trial) begin
        rem = rem - SizeW'(trial);
        s.base_q[b] = 1'b1;
      end
    end
    s.base_r = RemW'(rem);
    dbl = {s.base_r, 1'b0};
    if (dbl >= (RemW+1)'(den)) begin
      s.step_r = RemW'(dbl - (RemW+1)'(den));
      s.step_q = {s.base_q, 1'b1};
    end else begin
      s.step_r = RemW'(dbl);
      s.step_q = {s.base_q, 1'b0};
    end
    return s;
  endfunction

  localparam split_t RstColSplit = size_split(SizeW'(RstWidth), DenW'(ColDen));
  localparam split_t RstRowSplit = size_split(SizeW'(RstHeight), DenW'(RowDen));

endpackage
`default_nettype wire

@@ rtl/rgbnd_front.sv @@
// Front end: takes size writes, accepts source pixels, tracks position and pick points, queues kept pixels.
`timescale 1ns / 1ps
`default_nettype none
module rgbnd_front (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     cfg_we_i,
  input  wire rgbnd_pkg::reg_idx_e      cfg_index_i,
  input  wire logic [11:0]              cfg_wdata_i,
  input  wire logic                     accept_i,
  input  wire logic [15:0]              pixel_i,
  output      logic                     push_o,
  output      rgbnd_pkg::pick_item_t    push_item_o
);
  import rgbnd_pkg::*;

  logic [SizeW-1:0]   width_q, width_d, height_q, height_d;
  split_t             col_split_q, col_split_d, row_split_q, row_split_d;
  logic [SizeW-1:0]   src_col_q, src_col_d, src_row_q, src_row_d;
  logic [TgtColW-1:0] tgt_col_q, tgt_col_d;
  logic [TgtRowW-1:0] tgt_row_q, tgt_row_d;
  logic [SizeW-1:0]   pick_col_q, pick_col_d, pick_row_q, pick_row_d;
  logic [RemW-1:0]    col_rem_q, col_rem_d, row_rem_q, row_rem_d;

  logic [SizeW-1:0] clamped;
  logic             row_hit, hit, col_end, row_end, col_carry, row_carry;
  logic [RemW:0]    col_sum, row_sum;

  always_comb begin
    clamped = (cfg_wdata_i < SizeW'(TargetWidth)) ? SizeW'(TargetWidth) : cfg_wdata_i;
    if (cfg_index_i == RegSourceHeight) begin
      clamped = (cfg_wdata_i < SizeW'(TargetHeight)) ? SizeW'(TargetHeight) : cfg_wdata_i;
    end
    if (clamped > SizeW'(MaxSourceDim)) begin
      clamped = SizeW'(MaxSourceDim);
    end

    row_hit = (src_row_q == pick_row_q) && (tgt_row_q < TgtRowW'(TargetHeight));
    hit     = row_hit && (src_col_q == pick_col_q) && (tgt_col_q < TgtColW'(TargetWidth));
    col_end = ({1'b0, src_col_q} + (SizeW+1)'(1)) >= {1'b0, width_q};
    row_end = ({1'b0, src_row_q} + (SizeW+1)'(1)) >= {1'b0, height_q};

    col_sum   = {1'b0, col_rem_q} + {1'b0, col_split_q.step_r};
    col_carry = col_sum >= (RemW+1)'(ColDen);
    row_sum   = {1'b0, row_rem_q} + {1'b0, row_split_q.step_r};
    row_carry = row_sum >= (RemW+1)'(RowDen);

    width_d     = width_q;
    height_d    = height_q;
    col_split_d = col_split_q;
    row_split_d = row_split_q;
    src_col_d   = src_col_q;
    src_row_d   = src_row_q;
    tgt_col_d   = tgt_col_q;
    tgt_row_d   = tgt_row_q;
    pick_col_d  = pick_col_q;
    pick_row_d  = pick_row_q;
    col_rem_d   = col_rem_q;
    row_rem_d   = row_rem_q;
    push_o      = 1'b0;

    if (cfg_we_i) begin
      case (cfg_index_i)
        RegSourceWidth: begin
          width_d     = clamped;
          col_split_d = size_split(clamped, DenW'(ColDen));
        end
        RegSourceHeight: begin
          height_d    = clamped;
          row_split_d = size_split(clamped, DenW'(RowDen));
        end
        default: ;
      endcase
      src_col_d  = '0;
      src_row_d  = '0;
      tgt_col_d  = '0;
      tgt_row_d  = '0;
      pick_col_d = SizeW'(col_split_d.base_q);
      col_rem_d  = col_split_d.base_r;
      pick_row_d = SizeW'(row_split_d.base_q);
      row_rem_d  = row_split_d.base_r;
    end else if (accept_i) begin
      if (hit) begin
        push_o     = 1'b1;
        tgt_col_d  = tgt_col_q + TgtColW'(1);
        pick_col_d = pick_col_q + SizeW'(col_split_q.step_q) + SizeW'(col_carry);
        col_rem_d  = col_carry ? RemW'(col_sum - (RemW+1)'(ColDen)) : RemW'(col_sum);
      end
      if (col_end) begin
        src_col_d  = '0;
        tgt_col_d  = '0;
        pick_col_d = SizeW'(col_split_q.base_q);
        col_rem_d  = col_split_q.base_r;
        if (row_end) begin
          src_row_d  = '0;
          tgt_row_d  = '0;
          pick_row_d = SizeW'(row_split_q.base_q);
          row_rem_d  = row_split_q.base_r;
        end else begin
          if (row_hit) begin
            tgt_row_d  = tgt_row_q + TgtRowW'(1);
            pick_row_d = pick_row_q + SizeW'(row_split_q.step_q) + SizeW'(row_carry);
            row_rem_d  = row_carry ? RemW'(row_sum - (RemW+1)'(RowDen)) : RemW'(row_sum);
          end
          src_row_d = src_row_q + SizeW'(1);
        end
      end else begin
        src_col_d = src_col_q + SizeW'(1);
      end
    end

    push_item_o.pixel = pixel_i;
    push_item_o.tx    = CoordW'(tgt_col_q);
    push_item_o.ty    = CoordW'(tgt_row_q);
    push_item_o.last  = (tgt_col_q == TgtColW'(TargetWidth - 1)) &&
                        (tgt_row_q == TgtRowW'(TargetHeight - 1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q     <= SizeW'(RstWidth);
      height_q    <= SizeW'(RstHeight);
      col_split_q <= RstColSplit;
      row_split_q <= RstRowSplit;
      src_col_q   <= '0;
      src_row_q   <= '0;
      tgt_col_q   <= '0;
      tgt_row_q   <= '0;
      pick_col_q  <= SizeW'(RstColSplit.base_q);
      col_rem_q   <= RstColSplit.base_r;
      pick_row_q  <= SizeW'(RstRowSplit.base_q);
      row_rem_q   <= RstRowSplit.base_r;
    end else begin
      width_q     <= width_d;
      height_q    <= height_d;
      col_split_q <= col_split_d;
      row_split_q <= row_split_d;
      src_col_q   <= src_col_d;
      src_row_q   <= src_row_d;
      tgt_col_q   <= tgt_col_d;
      tgt_row_q   <= tgt_row_d;
      pick_col_q  <= pick_col_d;
      col_rem_q   <= col_rem_d;
      pick_row_q  <= pick_row_d;
      row_rem_q   <= row_rem_d;
    end
  end

endmodule
`default_nettype wire

@@ rtl/rgbnd_fifo.sv @@
// Short queue of kept pixels between the front end and the output stage.
`timescale 1ns / 1ps
`default_nettype none
module rgbnd_fifo #(
  parameter int Depth = rgbnd_pkg::FifoDepth
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  push_i,
  input  wire rgbnd_pkg::pick_item_t push_item_i,
  input  wire logic                  pop_i,
  output      rgbnd_pkg::pick_item_t pop_item_o,
  output      logic                  full_o,
  output      logic                  empty_o
);
  import rgbnd_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  pick_item_t      mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  always_comb begin
    full_o   = count_q == CntW'(Depth);
    empty_o  = count_q == '0;
    do_push  = push_i && !full_o;
    do_pop   = pop_i && !empty_o;
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CntW'(1);
    end
    pop_item_o = mem_q[rd_ptr_q];
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule
`default_nettype wire

@@ rtl/rgbnd_back.sv @@
// Back end: expands queued pixels to RGB888 into the output register.
`timescale 1ns / 1ps
`default_nettype none
module rgbnd_back (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  empty_i,
  input  wire rgbnd_pkg::pick_item_t item_i,
  output      logic                  pop_o,
  output      logic                  m_valid_o,
  input  wire logic                  m_ready_i,
  output      logic [39:0]           m_data_o,
  output      logic                  m_last_o
);
  import rgbnd_pkg::*;

  logic             valid_q, valid_d;
  logic [39:0]      data_q;
  logic             last_q;
  logic [ChanW-1:0] red, green, blue;

  always_comb begin
    pop_o   = !empty_i && (!valid_q || m_ready_i);
    valid_d = valid_q;
    if (pop_o) begin
      valid_d = 1'b1;
    end else if (m_ready_i) begin
      valid_d = 1'b0;
    end
    red   = {item_i.pixel[15:11], item_i.pixel[15:13]};
    green = {item_i.pixel[10:5], item_i.pixel[10:9]};
    blue  = {item_i.pixel[4:0], item_i.pixel[4:2]};
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      data_q <= {item_i.ty, item_i.tx, blue, green, red};
      last_q <= item_i.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign m_valid_o = valid_q;
  assign m_data_o  = data_q;
  assign m_last_o  = last_q;

endmodule
`default_nettype wire

@@ rtl/rgb565_nearest_downscale.sv @@
// Top level of the RGB565 to RGB888 nearest-neighbor downscaler.
// Takes one raster-order RGB565 pixel per clock while the queue is not full
// and keeps those that are the center-sampled nearest neighbors of a 224x224
// grid, emitting each kept pixel as RGB888 with its grid column and row; tlast
// marks the last grid pixel of a frame. A kept pixel passes through the queue
// and then the output register; the front end's position counters and pick
// trackers advance with adds and compares only, and a four-entry queue before
// the output register lets the input keep flowing while the output is stalled.
// A configuration write clamps the size into 224..4095 and restarts the frame.
`timescale 1ns / 1ps
`default_nettype none
module rgb565_nearest_downscale #(
  parameter int FIFO_DEPTH = rgbnd_pkg::FifoDepth
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire rgbnd_pkg::reg_idx_e cfg_index_i,
  input  wire logic [11:0]         cfg_wdata_i,
  input  wire logic                s_axis_tvalid,
  output      logic                s_axis_tready,
  input  wire logic [15:0]         s_axis_tdata,  // pixel[15:0]
  output      logic                m_axis_tvalid,
  input  wire logic                m_axis_tready,
  // red[7:0], green[15:8], blue[23:16], target_x[31:24], target_y[39:32]
  output      logic [39:0]         m_axis_tdata,
  output      logic                m_axis_tlast   // frame_done
);
  import rgbnd_pkg::*;

  logic       full, empty, push, pop, accept;
  pick_item_t push_item, pop_item;

  assign s_axis_tready = !full;
  assign accept        = s_axis_tvalid && !full;

  rgbnd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .accept_i    (accept),
    .pixel_i     (s_axis_tdata),
    .push_o      (push),
    .push_item_o (push_item)
  );

  rgbnd_fifo #(
    .Depth (FIFO_DEPTH)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .pop_i       (pop),
    .pop_item_o  (pop_item),
    .full_o      (full),
    .empty_o     (empty)
  );

  rgbnd_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .empty_i   (empty),
    .item_i    (pop_item),
    .pop_o     (pop),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .m_data_o  (m_axis_tdata),
    .m_last_o  (m_axis_tlast)
  );

endmodule
`default_nettype wire

@@ rtl/rgbnd_checker.sv @@
// Port-level assertions for the downscaler, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module rgbnd_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [39:0] m_axis_tdata,
  input wire logic        m_axis_tlast
);
  import rgbnd_pkg::*;

  a_hold_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("Output item dropped while stalled.");

  a_coord_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[31:24] < CoordW'(TargetWidth)) &&
                      (m_axis_tdata[39:32] < CoordW'(TargetHeight)))
    else $error("Target coordinate out of range.");

  a_last_corner : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tlast ==
      ((m_axis_tdata[31:24] == CoordW'(TargetWidth - 1)) &&
       (m_axis_tdata[39:32] == CoordW'(TargetHeight - 1)))))
    else $error("Frame end mark does not match the last grid pixel.");

  a_replicate : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[2:0] == m_axis_tdata[7:5]) &&
                      (m_axis_tdata[9:8] == m_axis_tdata[15:14]) &&
                      (m_axis_tdata[18:16] == m_axis_tdata[23:21]))
    else $error("Color channel is not a bit replication.");

endmodule

bind rgb565_nearest_downscale rgbnd_checker u_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
`default_nettype wire

@@ dv/rgb565_nearest_downscale_tb.sv @@
// Self-checking testbench for the RGB565 nearest-neighbor downscaler with a built-in pick predictor.
`timescale 1ns / 1ps
module rgb565_nearest_downscale_tb;
  import rgbnd_pkg::*;

  localparam int ColSpan      = 2 * TargetWidth;
  localparam int RowSpan      = 2 * TargetHeight;
  localparam int SettleCycles = 8;
  localparam int CycleLimit   = 2_000_000;

  typedef enum logic [1:0] {
    StimPixel,
    StimDrain,
    StimConfig
  } stim_kind_e;

  typedef struct {
    stim_kind_e  kind;
    reg_idx_e    idx;
    logic [15:0] data;
    int unsigned gap;
  } stim_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] tx;
    logic [7:0] ty;
    logic       last;
  } kept_px_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we = 1'b0;
  reg_idx_e    cfg_index = RegSourceWidth;
  logic [11:0] cfg_wdata = '0;
  logic        pix_valid = 1'b0;
  logic [15:0] pix_data = '0;
  logic        sink_ready = 1'b1;
  logic        s_axis_tready;
  logic        m_axis_tvalid;
  logic [39:0] m_axis_tdata;
  logic        m_axis_tlast;

  stim_t       stim_q[$];
  kept_px_t    kept_q[$];
  int          results_due = 0;
  int          settle_left = 0;
  int          sink_stall = 0;
  int          mismatches = 0;
  int          cycle_count = 0;

  // Predictor state of the downscaler.
  logic [11:0] src_w, src_h;
  logic [11:0] col_at, row_at;
  logic [7:0]  tcol, trow;
  logic [12:0] col_pick, row_pick;
  logic [8:0]  col_rem, row_rem;

  rgb565_nearest_downscale dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_index_i   (cfg_index),
    .cfg_wdata_i   (cfg_wdata),
    .s_axis_tvalid (pix_valid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (pix_data),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (sink_ready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  function automatic logic [11:0] clamp_dim(input logic [11:0] v, input int floor_dim);
    if (v < floor_dim) return 12'(floor_dim);
    if (v > MaxSourceDim) return 12'(MaxSourceDim);
    return v;
  endfunction

  task automatic advance_pick(inout logic [12:0] pick, inout logic [8:0] rem,
                              input logic [11:0] size, input int span);
    int step;
    int acc;
    step = 2 * int'(size);
    acc  = int'(rem) + step % span;
    pick = pick + 13'(step / span);
    if (acc >= span) begin
      acc  = acc - span;
      pick = pick + 13'd1;
    end
    rem = 9'(acc);
  endtask

  task automatic restart_grid();
    col_at   = '0;
    row_at   = '0;
    tcol     = '0;
    trow     = '0;
    col_pick = 13'(src_w / ColSpan);
    col_rem  = 9'(src_w % ColSpan);
    row_pick = 13'(src_h / RowSpan);
    row_rem  = 9'(src_h % RowSpan);
  endtask

  task automatic write_grid_reg(input reg_idx_e idx, input logic [11:0] value);
    case (idx)
      RegSourceWidth: begin
        src_w = clamp_dim(value, TargetWidth);
        restart_grid();
      end
      RegSourceHeight: begin
        src_h = clamp_dim(value, TargetHeight);
        restart_grid();
      end
      default: ;
    endcase
  endtask

  task automatic grid_step(input logic [15:0] px, output logic hit, output kept_px_t res);
    logic       row_hit;
    logic [4:0] r, b;
    logic [5:0] g;
    {r, g, b} = px;
    row_hit   = (row_at == row_pick) && (trow < TargetHeight);
    hit       = row_hit && (col_at == col_pick) && (tcol < TargetWidth);
    res.red   = {r, r[4:2]};
    res.green = {g, g[5:4]};
    res.blue  = {b, b[4:2]};
    res.tx    = tcol;
    res.ty    = trow;
    res.last  = (tcol == TargetWidth - 1) && (trow == TargetHeight - 1);
    if (hit) begin
      tcol = tcol + 8'd1;
      advance_pick(col_pick, col_rem, src_w, ColSpan);
    end
    if (32'(col_at) + 1 >= 32'(src_w)) begin
      col_at   = '0;
      tcol     = '0;
      col_pick = 13'(src_w / ColSpan);
      col_rem  = 9'(src_w % ColSpan);
      if (32'(row_at) + 1 >= 32'(src_h)) begin
        restart_grid();
      end else begin
        if (row_hit) begin
          trow = trow + 8'd1;
          advance_pick(row_pick, row_rem, src_h, RowSpan);
        end
        row_at = row_at + 12'd1;
      end
    end else begin
      col_at = col_at + 12'd1;
    end
  endtask

  task automatic flag_mismatch(input string what);
    mismatches++;
    if (mismatches <= 10) $display("%0t ns: %s", $realtime, what);
  endtask

  // Driver: pixels, configuration writes and pauses until the output side has drained.
  always @(posedge clk_i) begin
    logic        next_valid;
    logic [15:0] next_data;
    logic        next_we;
    next_valid = pix_valid;
    next_data  = pix_data;
    next_we    = 1'b0;
    if (rst_ni && !(pix_valid && !s_axis_tready)) begin
      next_valid = 1'b0;
      if (stim_q.size() != 0) begin
        case (stim_q[0].kind)
          StimPixel: begin
            if (stim_q[0].gap != 0) begin
              stim_q[0].gap = stim_q[0].gap - 1;
            end else begin
              next_valid = 1'b1;
              next_data  = stim_q[0].data;
              stim_q.pop_front();
            end
          end
          StimDrain: begin
            if (results_due != 0) begin
              settle_left <= 0;
            end else if (settle_left >= SettleCycles) begin
              settle_left <= 0;
              stim_q.pop_front();
            end else begin
              settle_left <= settle_left + 1;
            end
          end
          StimConfig: begin
            next_we = 1'b1;
            cfg_index <= stim_q[0].idx;
            cfg_wdata <= stim_q[0].data[11:0];
            stim_q.pop_front();
          end
          default: ;
        endcase
      end
    end
    pix_valid <= next_valid;
    pix_data  <= next_data;
    cfg_we    <= next_we;
  end

  // Monitor: tracks accepted items through the predictor, checks every kept pixel, stalls the sink.
  always @(posedge clk_i) begin
    kept_px_t got, want;
    logic     hit;
    int       stall;
    if (rst_ni) begin
      if (cfg_we) write_grid_reg(cfg_index, cfg_wdata);
      if (pix_valid && s_axis_tready) begin
        grid_step(pix_data, hit, want);
        if (hit) kept_q.push_back(want);
      end
      if (m_axis_tvalid && sink_ready) begin
        got = '{red: m_axis_tdata[7:0], green: m_axis_tdata[15:8],
                blue: m_axis_tdata[23:16], tx: m_axis_tdata[31:24],
                ty: m_axis_tdata[39:32], last: m_axis_tlast};
        if (kept_q.size() == 0) begin
          flag_mismatch($sformatf("unexpected pixel r=%02h g=%02h b=%02h x=%0d y=%0d last=%0b",
                                  got.red, got.green, got.blue, got.tx, got.ty, got.last));
        end else begin
          want = kept_q.pop_front();
          if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue ||
              got.tx !== want.tx || got.ty !== want.ty || got.last !== want.last) begin
            flag_mismatch($sformatf({"expected r=%02h g=%02h b=%02h x=%0d y=%0d last=%0b, ",
                                     "got r=%02h g=%02h b=%02h x=%0d y=%0d last=%0b"},
                                    want.red, want.green, want.blue, want.tx, want.ty,
                                    want.last, got.red, got.green, got.blue, got.tx,
                                    got.ty, got.last));
          end
        end
        stall = (cycle_count[10:9] == 2'd0) ? 0 : $urandom_range(0, 7);
        sink_stall <= stall;
        sink_ready <= (stall == 0);
      end else if (!sink_ready) begin
        if (sink_stall <= 1) sink_ready <= 1'b1;
        sink_stall <= sink_stall - 1;
      end
      results_due <= kept_q.size();
    end
  end

  task automatic push_pixel(input logic [15:0] px, input int unsigned gap);
    stim_t s;
    s = '{kind: StimPixel, idx: RegSourceWidth, data: px, gap: gap};
    stim_q.push_back(s);
  endtask

  task automatic push_drain();
    stim_t s;
    s = '{kind: StimDrain, idx: RegSourceWidth, data: '0, gap: 0};
    stim_q.push_back(s);
  endtask

  task automatic push_config(input reg_idx_e idx, input logic [11:0] value);
    stim_t s;
    s = '{kind: StimConfig, idx: idx, data: {4'h0, value}, gap: 0};
    push_drain();
    stim_q.push_back(s);
  endtask

  // Random pixels; a pause for the output side is inserted before item pause_at when nonzero.
  task automatic push_pixels(input int count, input int pause_at);
    logic burst;
    burst = 1'b0;
    for (int i = 0; i < count; i++) begin
      if (i % 64 == 0) burst = ($urandom_range(0, 3) == 0);
      if (pause_at != 0 && i == pause_at) push_drain();
      push_pixel(16'($urandom_range(0, 65535)), burst ? 0 : $urandom_range(0, 7));
    end
  endtask

  initial begin
    logic [11:0] w, h;
    src_w = 12'(RstWidth);
    src_h = 12'(RstHeight);
    restart_grid();

    // Reset sizes: color extremes and single channels, most of them kept.
    push_pixel(16'h0000, 0);
    push_pixel(16'hffff, 0);
    push_pixel(16'hf800, 1);
    push_pixel(16'h07e0, 0);
    push_pixel(16'h001f, 2);
    push_pixel(16'h8410, 0);
    push_pixel(16'h7bef, 3);
    push_pixel(16'h0821, 0);
    push_pixel(16'haaaa, 0);
    push_pixel(16'h5555, 1);
    push_pixel(16'hffff, 0);
    push_pixel(16'h0000, 0);
    push_pixels(500, 250);

    // Width below the target saturates up; tallest frame skips the first rows.
    push_config(RegSourceWidth, 12'd0);
    push_config(RegSourceHeight, 12'd4095);
    push_pixels(250, 0);

    // Widest row, height below the target saturates up.
    push_config(RegSourceWidth, 12'd4095);
    push_config(RegSourceHeight, 12'd5);
    push_pixels(300, 0);

    // One-to-one grid: every pixel is kept and rows wrap.
    push_config(RegSourceHeight, 12'd223);
    push_config(RegSourceWidth, 12'd224);
    push_pixels(300, 150);

    for (int p = 0; p < 6; p++) begin
      w = ($urandom_range(0, 3) == 0) ? 12'($urandom_range(0, 4095)) : 12'($urandom_range(0, 700));
      h = ($urandom_range(0, 3) == 0) ? 12'($urandom_range(0, 4095)) : 12'($urandom_range(0, 447));
      if ($urandom_range(0, 1) == 0) begin
        push_config(RegSourceWidth, w);
        push_config(RegSourceHeight, h);
      end else begin
        push_config(RegSourceHeight, h);
        push_config(RegSourceWidth, w);
      end
      push_pixels(65, 0);
    end

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (stim_q.size() != 0 || pix_valid || results_due != 0) @(posedge clk_i);
    repeat (2 * SettleCycles) @(posedge clk_i);
    if (kept_q.size() != 0) begin
      flag_mismatch($sformatf("%0d expected pixels never arrived", kept_q.size()));
    end
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    wait (cycle_count == CycleLimit);
    $display("timeout after %0d cycles", cycle_count);
    $display("FAIL");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/rgbnd_pkg.sv
rtl/rgbnd_front.sv
rtl/rgbnd_fifo.sv
rtl/rgbnd_back.sv
rtl/rgb565_nearest_downscale.sv
rtl/rgbnd_checker.sv
dv/rgb565_nearest_downscale_tb.sv
